@@ src/slbr_pkg.sv @@
// Shared constants and helper functions for the shuffled Lehmer bounded random generator.
package slbr_pkg;

	localparam int TABLE_ENTRIES = 32;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int WARM_STEPS    = TABLE_ENTRIES + 8;
	localparam int CNT_W         = $clog2(WARM_STEPS);

	localparam int WORD_W   = 32;
	localparam int WCNT_W   = $clog2(WORD_W);
	localparam int PROD_W   = 47;

	localparam logic [14:0] LEH_A     = 15'd16807;
	localparam logic [31:0] LEH_M     = 32'h7FFF_FFFF;
	localparam logic [30:0] DRAW_MAX  = 31'h7FFF_FFFF;
	localparam int          SEED_BIAS = 22261048;
	localparam int          SEED_EDGE = 1000;
	localparam int          SLOT_DIV  = 1 + (2147483647 - 1) / TABLE_ENTRIES;

	// Seed transform applied on a write and on first use.
	function automatic logic [31:0] seed_load(input logic [31:0] seed);
		logic signed [31:0] s;
		s = $signed(seed);
		if (s == 32'sd0)
			s = 32'sd1;
		if (s > 32'(SEED_EDGE))
			s = -s;
		else if (s > -32'(SEED_EDGE))
			s = s - 32'(SEED_BIAS);
		return s;
	endfunction

	// Reduce 16807 * x modulo 2^31 - 1 by folding the bits above bit 30 back in.
	function automatic logic [30:0] lehmer_fold(input logic [PROD_W-1:0] p);
		logic [31:0] sum;
		sum = {1'b0, p[30:0]} + 32'(p[PROD_W-1:31]);
		if (sum >= LEH_M)
			sum = sum - LEH_M;
		return sum[30:0];
	endfunction

	// Slot picked by the previous output; clamped although it cannot overrun.
	function automatic logic [IDX_W-1:0] slot_index(input logic [30:0] so);
		logic [30:0] q;
		q = 31'(so / SLOT_DIV);
		if (q >= 31'(TABLE_ENTRIES))
			return IDX_W'(TABLE_ENTRIES - 1);
		return q[IDX_W-1:0];
	endfunction

endpackage

@@ src/slbr_rem.sv @@
// Iterative restoring remainder unit, one quotient bit per cycle.
module slbr_rem (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [slbr_pkg::WORD_W-1:0]  dividend,
	input  logic [slbr_pkg::WORD_W-1:0]  divisor,
	output logic                         done,
	output logic [slbr_pkg::WORD_W-1:0]  remainder
);

	logic                          busy_q;
	logic                          done_q;
	logic [slbr_pkg::WCNT_W-1:0]   cnt_q;
	logic [slbr_pkg::WORD_W-1:0]   dvd_q;
	logic [slbr_pkg::WORD_W-1:0]   dsr_q;
	logic [slbr_pkg::WORD_W-1:0]   rem_q;
	logic [slbr_pkg::WORD_W-1:0]   trial;
	logic [slbr_pkg::WORD_W:0]     diff;

	// remainder stays below the divisor (at most 2^31), so its top bit is free
	assign trial = {rem_q[slbr_pkg::WORD_W-2:0], dvd_q[slbr_pkg::WORD_W-1]};
	assign diff  = {1'b0, trial} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			dsr_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				dvd_q  <= dividend;
				dsr_q  <= divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				dvd_q <= dvd_q << 1;
				rem_q <= diff[slbr_pkg::WORD_W] ? trial : diff[slbr_pkg::WORD_W-1:0];
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == slbr_pkg::WCNT_W'(slbr_pkg::WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

@@ src/shuffled_lcg_bounded_random.sv @@
// Top level of the shuffled Lehmer bounded random generator.
//
// Usage:
//  - Request channel (in_valid/in_ready, range_low, range_high): one item per
//    request, giving an inclusive signed range. Result channel (out_valid/
//    out_ready, value): one item per request, a uniform integer in the range,
//    or range_low when the range is empty or wider than 2^31 values.
//  - cfg_wen/cfg_wdata writes the seed; it is transformed and loaded into the
//    generator at once. Write only while no request is in flight.
//  - One request at a time; in_ready is high only when idle, from the cycle after posting.
//  - After a request is taken, an invalid range goes straight to posting. A valid
//    range computes the rejection bound, makes draws until one is accepted,
//    reduces that draw and posts the result. A table refill adds 40 generator
//    steps, each a multiply and then a fold. The bound and the reduction each
//    run the 32-step remainder unit, with a registered start and a waiting state.
//  - If the receiver stalls, the finished result waits in its state and then
//    in the output register; a new request may be taken while the last
//    result is still unread.
//  - Reset: seed 1, generator unseeded, no result pending. The shuffle table
//    is not cleared; it is always refilled before it is read.
module shuffled_lcg_bounded_random (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] range_low,
	input  logic [31:0] range_high,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] value
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAXOK,
		ST_CHK,
		ST_WARM_MUL,
		ST_WARM_FOLD,
		ST_STEP_MUL,
		ST_STEP_FOLD,
		ST_REJ,
		ST_RES,
		ST_DONE
	} state_t;

	state_t                         state_q;
	logic [31:0]                    seed_q;
	logic [31:0]                    generator_q;
	logic [30:0]                    shuffle_out_q;
	logic [31:0]                    lo_q;
	logic [31:0]                    size_q;
	logic [30:0]                    max_ok_q;
	logic [31:0]                    res_q;
	logic [slbr_pkg::CNT_W-1:0]     cnt_q;
	logic [slbr_pkg::IDX_W-1:0]     j_q;
	logic [slbr_pkg::PROD_W-1:0]    prod_q;
	logic                           rem_start_q;
	logic [31:0]                    rem_dvd_q;
	logic                           out_valid_q;
	logic [31:0]                    value_q;

	logic [31:0]                    span;
	logic signed [32:0]             neg_gen;
	logic [31:0]                    warm_start;
	logic [30:0]                    gen_next;
	logic                           rem_done;
	logic [31:0]                    rem_remainder;

	// shuffle table, read with registered data
	logic [30:0]                    shuf_mem [slbr_pkg::TABLE_ENTRIES];
	logic [30:0]                    rd_q;
	logic                           mem_we;
	logic [slbr_pkg::IDX_W-1:0]     mem_waddr;
	logic [slbr_pkg::IDX_W-1:0]     mem_raddr;

	// range check: bit 31 of hi - lo set means size 0 or above 2^31
	assign span = range_high - range_low;

	// warm-up starts from max(1, -generator); 2^31 is carried as unsigned
	assign neg_gen    = -$signed({generator_q[31], generator_q});
	assign warm_start = (neg_gen < 33'sd1) ? 32'd1 : neg_gen[31:0];

	assign gen_next  = slbr_pkg::lehmer_fold(prod_q);
	assign mem_raddr = slbr_pkg::slot_index(shuffle_out_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = j_q;
		case (state_q)
			ST_WARM_FOLD: begin
				// first eight warm-up steps are thrown away
				mem_we    = cnt_q < slbr_pkg::CNT_W'(slbr_pkg::TABLE_ENTRIES);
				mem_waddr = cnt_q[slbr_pkg::IDX_W-1:0];
			end
			ST_STEP_FOLD: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			shuf_mem[mem_waddr] <= gen_next;
		rd_q <= shuf_mem[mem_raddr];
	end

	// Shared remainder unit: 2^31 mod size for the bound, then draw mod size.
	slbr_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start_q),
		.dividend  (rem_dvd_q),
		.divisor   (size_q),
		.done      (rem_done),
		.remainder (rem_remainder)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			seed_q        <= 32'd1;
			generator_q   <= '0;
			shuffle_out_q <= '0;
			lo_q          <= '0;
			size_q        <= '0;
			max_ok_q      <= '0;
			res_q         <= '0;
			cnt_q         <= '0;
			j_q           <= '0;
			prod_q        <= '0;
			rem_start_q   <= 1'b0;
			rem_dvd_q     <= '0;
			out_valid_q   <= 1'b0;
			value_q       <= '0;
		end else begin
			rem_start_q <= 1'b0;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (cfg_wen) begin
				seed_q      <= cfg_wdata;
				generator_q <= slbr_pkg::seed_load(cfg_wdata);
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						lo_q   <= range_low;
						size_q <= span + 32'd1;
						// first use seeds the generator, even for a bad range
						if (generator_q == '0)
							generator_q <= slbr_pkg::seed_load(seed_q);
						if (span[31]) begin
							res_q   <= range_low;
							state_q <= ST_DONE;
						end else begin
							rem_dvd_q   <= 32'h8000_0000;
							rem_start_q <= 1'b1;
							state_q     <= ST_MAXOK;
						end
					end
				end
				ST_MAXOK: begin
					if (rem_done) begin
						max_ok_q <= slbr_pkg::DRAW_MAX - rem_remainder[30:0];
						state_q  <= ST_CHK;
					end
				end
				ST_CHK: begin
					if ($signed(generator_q) <= 32'sd0 || shuffle_out_q == '0) begin
						generator_q <= warm_start;
						cnt_q       <= slbr_pkg::CNT_W'(slbr_pkg::WARM_STEPS - 1);
						state_q     <= ST_WARM_MUL;
					end else begin
						state_q <= ST_STEP_MUL;
					end
				end
				ST_WARM_MUL: begin
					prod_q  <= slbr_pkg::PROD_W'(generator_q) * slbr_pkg::PROD_W'(slbr_pkg::LEH_A);
					state_q <= ST_WARM_FOLD;
				end
				ST_WARM_FOLD: begin
					generator_q <= {1'b0, gen_next};
					if (cnt_q == '0) begin
						// last value written is also slot 0
						shuffle_out_q <= gen_next;
						state_q       <= ST_STEP_MUL;
					end else begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= ST_WARM_MUL;
					end
				end
				ST_STEP_MUL: begin
					prod_q  <= slbr_pkg::PROD_W'(generator_q) * slbr_pkg::PROD_W'(slbr_pkg::LEH_A);
					j_q     <= mem_raddr;
					state_q <= ST_STEP_FOLD;
				end
				ST_STEP_FOLD: begin
					// old slot content goes out, fresh generator value goes in
					generator_q   <= {1'b0, gen_next};
					shuffle_out_q <= rd_q;
					state_q       <= ST_REJ;
				end
				ST_REJ: begin
					if (shuffle_out_q > max_ok_q) begin
						state_q <= ST_CHK;
					end else begin
						rem_dvd_q   <= {1'b0, shuffle_out_q};
						rem_start_q <= 1'b1;
						state_q     <= ST_RES;
					end
				end
				ST_RES: begin
					if (rem_done) begin
						res_q   <= lo_q + rem_remainder;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						value_q     <= res_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign value     = value_q;

`ifndef SYNTH
	// an accepted request always leaves the idle state
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != ST_IDLE)
		else $error("request accepted but sequencer stayed idle");

	// remainder unit only reports while the sequencer waits for it
	a_rem_owner: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> (state_q == ST_MAXOK || state_q == ST_RES))
		else $error("remainder result outside a waiting state");

	// remainder is always below the range size
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> rem_remainder < size_q)
		else $error("remainder not below range size");

	// a generator step always lands below the modulus
	a_gen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_STEP_FOLD |=> generator_q < slbr_pkg::LEH_M)
		else $error("generator out of range after step");
`endif

endmodule
